FILE: rtl/core/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg: shared types and constants for the grid wall follower
// Holds the field widths, register indexes, heading codes, the controller
// state type and the command and status bundles between the two modules.
// ----------------------------------------------------------------------------
package gwf_pkg;

	localparam int MAX_SIDE_DEF = 8;
	localparam int MAP_W        = 64;
	localparam int SIDE_W       = 4;
	localparam int IDX_W        = 6;
	localparam int DIR_W        = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WALL_MAP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;      // item accepted: clear try counter and stuck flag
		logic step_try;   // current direction blocked, try the next one
		logic take_move;  // current direction open, move there
		logic set_stuck;  // all four directions blocked
		logic emit;       // load the output register
	} cmd_t;

	typedef struct packed {
		logic go;         // advance requested and walker not on last cell
		logic open;       // candidate neighbor is open
		logic last_try;   // fourth direction is under test
		logic out_free;   // output register can take a result
	} status_t;

endpackage

FILE: rtl/core/grid_wall_follower_step.sv
// ----------------------------------------------------------------------------
// grid_wall_follower_step: right-hand wall follower on a small grid maze
// Each item on the input channel either moves the walker one cell or only
// reports its position; one result item comes back for every input item.
// ----------------------------------------------------------------------------
// Usage:
// The maze is set through the configuration channel: register 0 is the
// 64-bit wall map, register 1 the row width, register 2 the row count.
// Configuration writes are always taken (cfg_ready is tied high) and are
// meant to happen only while no item is in flight.
// An input item carries one bit, advance. With advance low, or with the
// walker already on the last cell, the result reports the current place.
// Otherwise the datapath tests the neighbor on the right-hand side, then
// straight ahead, then left, then back, one neighbor per clock cycle, and
// moves to the first open one; with none open the walker stays and the
// result flags stuck.
// A report goes from acceptance straight to loading the output register; a
// move first makes one to four neighbor tests on the single neighbor test
// unit, then loads the output register. One item is worked at a time. The
// next item is taken once the result has moved into the output register, so
// a result may wait there while the next item is worked. If the receiver
// stalls with a result still held, the controller waits before loading a new
// one; nothing is dropped. Reset puts the walker on cell 0 facing right,
// clears the wall map and sets the grid to 6 by 5.
// ----------------------------------------------------------------------------
module grid_wall_follower_step #(
	parameter int MAX_SIDE = gwf_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gwf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gwf_pkg::MAP_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gwf_pkg::IDX_W-1:0]     cell_index,
	output logic [gwf_pkg::DIR_W-1:0]     heading,
	output logic                          arrived,
	output logic                          stuck
);
	import gwf_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	cmd_t    cmd;
	status_t sts;

	gwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gwf_dpath #(
		.MAX_SIDE (MAX_SIDE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_index (cell_index),
		.heading    (heading),
		.arrived    (arrived),
		.stuck      (stuck),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

FILE: rtl/core/gwf_ctrl.sv
// ----------------------------------------------------------------------------
// gwf_ctrl: controller of the grid wall follower
// Sequences acceptance, up to four neighbor checks and the result hand-off.
// ----------------------------------------------------------------------------
module gwf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gwf_pkg::status_t sts,
	output gwf_pkg::cmd_t    cmd
);
	import gwf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.go ? ST_CHECK : ST_EMIT;
				end
			end
			ST_CHECK: begin
				if (sts.open || sts.last_try) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_CHECK: begin
				cmd.take_move = sts.open;
				cmd.set_stuck = !sts.open && sts.last_try;
				cmd.step_try  = !sts.open && !sts.last_try;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/gwf_dpath.sv
// ----------------------------------------------------------------------------
// gwf_dpath: datapath of the grid wall follower
// Holds the maze registers, walker state, the neighbor test and the output
// register.
// ----------------------------------------------------------------------------
module gwf_dpath #(
	parameter int MAX_SIDE = gwf_pkg::MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gwf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gwf_pkg::MAP_W-1:0]       cfg_data,
	input  logic                            advance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gwf_pkg::IDX_W-1:0]       cell_index,
	output logic [gwf_pkg::DIR_W-1:0]       heading,
	output logic                            arrived,
	output logic                            stuck,
	input  gwf_pkg::cmd_t                   cmd,
	output gwf_pkg::status_t                sts
);
	import gwf_pkg::*;

	localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic [MAP_W-1:0]  wall_map_q;
	logic [SIDE_W-1:0] grid_width_q;
	logic [SIDE_W-1:0] grid_height_q;
	logic [PW-1:0]     pos_x_q;
	logic [PW-1:0]     pos_y_q;
	logic [DIR_W-1:0]  facing_q;
	logic [1:0]        try_q;
	logic              stuck_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  cell_index_q;
	logic [DIR_W-1:0]  heading_q;
	logic              arrived_q;
	logic              stuck_out_q;

	logic [SIDE_W-1:0] eff_w;
	logic [SIDE_W-1:0] eff_h;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  last_idx;
	logic              at_last;
	logic [DIR_W-1:0]  dir;
	logic [PW:0]       nx;
	logic [PW:0]       ny;
	logic              in_bounds;
	logic [IDX_W-1:0]  wall_bit;
	logic              nb_open;

	assign cfg_ready = 1'b1;

	// Sizes out of range are clamped to 1..MAX_SIDE.
	always_comb begin
		eff_w = grid_width_q;
		if (grid_width_q == '0) begin
			eff_w = SIDE_W'(1);
		end else if (grid_width_q > SIDE_W'(MAX_SIDE)) begin
			eff_w = SIDE_W'(MAX_SIDE);
		end
		eff_h = grid_height_q;
		if (grid_height_q == '0) begin
			eff_h = SIDE_W'(1);
		end else if (grid_height_q > SIDE_W'(MAX_SIDE)) begin
			eff_h = SIDE_W'(MAX_SIDE);
		end
	end

	assign idx      = IDX_W'(IDX_W'(pos_y_q) * IDX_W'(eff_w) + IDX_W'(pos_x_q));
	assign last_idx = IDX_W'(IDX_W'(eff_w) * IDX_W'(eff_h) - IDX_W'(1));
	assign at_last  = (idx == last_idx);

	// Try order: right of facing, straight, left, back.
	assign dir = DIR_W'(facing_q + DIR_W'(1) - try_q);

	always_comb begin
		nx        = {1'b0, pos_x_q};
		ny        = {1'b0, pos_y_q};
		in_bounds = 1'b0;
		case (dir)
			DIR_RIGHT: begin
				nx        = {1'b0, pos_x_q} + (PW+1)'(1);
				in_bounds = SIDE_W'(nx) < eff_w && SIDE_W'(ny) < eff_h;
			end
			DIR_DOWN: begin
				ny        = {1'b0, pos_y_q} + (PW+1)'(1);
				in_bounds = SIDE_W'(nx) < eff_w && SIDE_W'(ny) < eff_h;
			end
			DIR_LEFT: begin
				nx        = {1'b0, pos_x_q} - (PW+1)'(1);
				in_bounds = (pos_x_q != '0) && SIDE_W'(nx) < eff_w && SIDE_W'(ny) < eff_h;
			end
			DIR_UP: begin
				ny        = {1'b0, pos_y_q} - (PW+1)'(1);
				in_bounds = (pos_y_q != '0) && SIDE_W'(nx) < eff_w && SIDE_W'(ny) < eff_h;
			end
			default: in_bounds = 1'b0;
		endcase
	end

	assign wall_bit = IDX_W'(IDX_W'(ny) * IDX_W'(eff_w) + IDX_W'(nx));
	assign nb_open  = in_bounds && !wall_map_q[wall_bit];

	assign sts.go       = advance && !at_last;
	assign sts.open     = nb_open;
	assign sts.last_try = (try_q == 2'd3);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q    <= '0;
			grid_width_q  <= SIDE_W'(6);
			grid_height_q <= SIDE_W'(5);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WALL_MAP:    wall_map_q    <= cfg_data;
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[SIDE_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[SIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			facing_q <= DIR_RIGHT;
			try_q    <= '0;
			stuck_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				try_q   <= '0;
				stuck_q <= 1'b0;
			end
			if (cmd.step_try) begin
				try_q <= try_q + 2'd1;
			end
			if (cmd.set_stuck) begin
				stuck_q <= 1'b1;
			end
			if (cmd.take_move) begin
				pos_x_q  <= nx[PW-1:0];
				pos_y_q  <= ny[PW-1:0];
				facing_q <= dir;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cell_index_q <= idx;
			heading_q    <= facing_q;
			arrived_q    <= at_last;
			stuck_out_q  <= stuck_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_index = cell_index_q;
	assign heading    = heading_q;
	assign arrived    = arrived_q;
	assign stuck      = stuck_out_q;

endmodule
